/* hw/rtl/salc_pkg.sv */
// Shared constants and command type for the set-associative LRU cache lookup.
`timescale 1ns / 1ps

package salc_pkg;

	localparam int MAX_WAYS  = 8;
	localparam int MAX_SETS  = 1024;
	localparam int ADDR_BITS = 32;

	localparam int WAY_W   = $clog2(MAX_WAYS);
	localparam int WAYS_W  = WAY_W + 1;
	localparam int SET_W   = $clog2(MAX_SETS);
	localparam int TAG_W   = ADDR_BITS;
	localparam int RANK_W  = WAY_W;
	localparam int SHIFT_W = 6;

	localparam int OFFB_W = 5;
	localparam int IDXB_W = 4;
	localparam int WIU_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [OFFB_W-1:0] OFFB_RESET = 5'd2;
	localparam logic [IDXB_W-1:0] IDXB_RESET = 4'd10;
	localparam logic [WIU_W-1:0]  WIU_RESET  = 4'd8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;     // capture address split into set and tag
		logic             read;     // read the set's rows
		logic             lookup;   // compare, pick way, build new rows
		logic             write;    // write rows back, load result register
		logic             clr_en;   // clear one row of valid bits
		logic [SET_W-1:0] clr_set;
	} cmd_t;

endpackage

/* hw/rtl/salc_ctrl.sv */
// Controller state machine: clearing pass, item sequencing and result handshake.
`timescale 1ns / 1ps

module salc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output salc_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOOKUP,
		ST_WRITE
	} state_t;

	state_t                         state_q;
	logic                           out_valid_q;
	logic [salc_pkg::SET_W-1:0]     clr_cnt_q;
	logic                           slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clr_set = clr_cnt_q;
		unique case (state_q)
			ST_CLEAR:  cmd.clr_en = 1'b1;
			ST_IDLE:   cmd.load   = in_valid;
			ST_READ:   cmd.read   = 1'b1;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_WRITE:  cmd.write  = slot_free;
			default:   cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
			clr_cnt_q   <= '0;
		end else begin
			// A write-back loads a new result; otherwise drop the one just taken.
			if (cmd.write) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == salc_pkg::SET_W'(salc_pkg::MAX_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:   state_q <= ST_LOOKUP;
				ST_LOOKUP: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	a_read_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.read)
		else $error("row read did not follow an accepted item");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> (!out_valid_q || out_ready))
		else $error("result register loaded while previous result pending");

	a_result_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> out_valid_q)
		else $error("write-back did not present a result");

endmodule

/* hw/rtl/salc_dp.sv */
// Datapath: config registers, address split, set memories, compare and LRU update.
`timescale 1ns / 1ps

module salc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  salc_pkg::cmd_t                  cmd,
	input  logic [salc_pkg::ADDR_BITS-1:0]  address,
	output logic                            hit,
	output logic [salc_pkg::WAY_W-1:0]      way
);

	localparam int NW = salc_pkg::MAX_WAYS;
	localparam int NS = salc_pkg::MAX_SETS;

	typedef logic [NW-1:0][salc_pkg::TAG_W-1:0]  tag_row_t;
	typedef logic [NW-1:0][salc_pkg::RANK_W-1:0] rank_row_t;
	typedef logic [NW-1:0]                       valid_row_t;

	logic [salc_pkg::OFFB_W-1:0] offb_q;
	logic [salc_pkg::IDXB_W-1:0] idxb_q;
	logic [salc_pkg::WIU_W-1:0]  wiu_q;

	tag_row_t   tag_mem   [NS];
	rank_row_t  rank_mem  [NS];
	valid_row_t valid_mem [NS];

	logic [salc_pkg::SET_W-1:0]   set_s1;
	logic [salc_pkg::TAG_W-1:0]   tag_s1;
	tag_row_t                     tag_row_q;
	rank_row_t                    rank_row_q;
	valid_row_t                   valid_row_q;
	logic                         hit_s2;
	logic [salc_pkg::WAY_W-1:0]   way_s2;
	rank_row_t                    rank_s2;
	valid_row_t                   valid_s2;
	logic                         hit_q;
	logic [salc_pkg::WAY_W-1:0]   way_q;

	logic [salc_pkg::ADDR_BITS-1:0] addr_sh;
	logic [salc_pkg::SET_W-1:0]     imask;
	logic [salc_pkg::SHIFT_W-1:0]   tag_sh;
	logic [salc_pkg::SET_W-1:0]     set_c;
	logic [salc_pkg::TAG_W-1:0]     tag_c;
	logic [salc_pkg::WAYS_W-1:0]    ways_eff;
	logic [salc_pkg::RANK_W-1:0]    top;
	valid_row_t                     in_use;
	valid_row_t                     live;
	logic                           hit_c;
	logic [salc_pkg::WAY_W-1:0]     hit_way;
	logic                           free_c;
	logic [salc_pkg::WAY_W-1:0]     free_way;
	logic [salc_pkg::WAY_W-1:0]     vic_way;
	logic [salc_pkg::WAY_W-1:0]     chosen;
	logic [salc_pkg::RANK_W-1:0]    limit;
	rank_row_t                      rank_c;
	tag_row_t                       tag_wr;

	// Config registers; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offb_q <= salc_pkg::OFFB_RESET;
			idxb_q <= salc_pkg::IDXB_RESET;
			wiu_q  <= salc_pkg::WIU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				salc_pkg::CFG_OFFSET_BITS: offb_q <= cfg_data;
				salc_pkg::CFG_INDEX_BITS:  idxb_q <= cfg_data[salc_pkg::IDXB_W-1:0];
				salc_pkg::CFG_WAYS_IN_USE: wiu_q  <= cfg_data[salc_pkg::WIU_W-1:0];
				default: ;
			endcase
		end
	end

	// Address split.
	always_comb begin
		addr_sh = address >> offb_q;
		imask   = ~({salc_pkg::SET_W{1'b1}} << idxb_q);
		set_c   = addr_sh[salc_pkg::SET_W-1:0] & imask;
		tag_sh  = salc_pkg::SHIFT_W'(offb_q) + salc_pkg::SHIFT_W'(idxb_q);
		if (tag_sh >= salc_pkg::SHIFT_W'(salc_pkg::ADDR_BITS)) begin
			tag_c = '0;
		end else begin
			tag_c = salc_pkg::TAG_W'(address >> tag_sh);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_s1 <= set_c;
			tag_s1 <= tag_c;
		end
	end

	// Row reads, registered.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			tag_row_q   <= tag_mem[set_s1];
			rank_row_q  <= rank_mem[set_s1];
			valid_row_q <= valid_mem[set_s1];
		end
	end

	// Compare, way choice and rank update.
	always_comb begin
		if (wiu_q == '0) begin
			ways_eff = salc_pkg::WAYS_W'(1);
		end else if (salc_pkg::WAYS_W'(wiu_q) > salc_pkg::WAYS_W'(NW)) begin
			ways_eff = salc_pkg::WAYS_W'(NW);
		end else begin
			ways_eff = salc_pkg::WAYS_W'(wiu_q);
		end
		top = salc_pkg::RANK_W'(ways_eff - 1'b1);

		hit_c    = 1'b0;
		hit_way  = '0;
		free_c   = 1'b0;
		free_way = '0;
		vic_way  = '0;
		for (int w = 0; w < NW; w++) begin
			in_use[w] = salc_pkg::WAYS_W'(w) < ways_eff;
			live[w]   = in_use[w] && valid_row_q[w];
			// highest matching way wins
			if (live[w] && tag_row_q[w] == tag_s1) begin
				hit_c   = 1'b1;
				hit_way = salc_pkg::WAY_W'(w);
			end
			if (in_use[w] && !valid_row_q[w] && !free_c) begin
				free_c   = 1'b1;
				free_way = salc_pkg::WAY_W'(w);
			end
			// strict compare keeps the lowest way on a rank tie
			if (in_use[w] && rank_row_q[w] > rank_row_q[vic_way]) begin
				vic_way = salc_pkg::WAY_W'(w);
			end
		end

		if (hit_c) begin
			chosen = hit_way;
		end else if (free_c) begin
			chosen = free_way;
		end else begin
			chosen = vic_way;
		end
		limit = rank_row_q[chosen];

		for (int w = 0; w < NW; w++) begin
			if (salc_pkg::WAY_W'(w) == chosen) begin
				rank_c[w] = '0;
			end else if (live[w] && ((!hit_c && free_c) || rank_row_q[w] < limit)
					&& rank_row_q[w] < top) begin
				rank_c[w] = rank_row_q[w] + 1'b1;
			end else begin
				rank_c[w] = rank_row_q[w];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s2   <= hit_c;
			way_s2   <= chosen;
			rank_s2  <= rank_c;
			valid_s2 <= valid_row_q | (valid_row_t'(1) << chosen);
		end
	end

	// On a hit the stored tag already equals the new one.
	always_comb begin
		tag_wr         = tag_row_q;
		tag_wr[way_s2] = tag_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			tag_mem[set_s1]  <= tag_wr;
			rank_mem[set_s1] <= rank_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			valid_mem[cmd.clr_set] <= '0;
		end else if (cmd.write) begin
			valid_mem[set_s1] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			hit_q <= hit_s2;
			way_q <= way_s2;
		end
	end

	assign hit = hit_q;
	assign way = way_q;

	a_chosen_marked_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.lookup) |-> valid_s2[way_s2])
		else $error("chosen way not marked valid");

	a_chosen_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.lookup) |-> (rank_s2[way_s2] == '0))
		else $error("chosen way not made most recent");

	a_hit_on_valid_line: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.lookup) && hit_s2) |-> valid_row_q[way_s2])
		else $error("hit reported on an invalid line");

endmodule

/* hw/rtl/set_assoc_lru_cache_lookup.sv */
// Top level of the set-associative cache lookup with exact LRU replacement.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[4:0]
// in        in_valid / in_ready     address[31:0]
// out       out_valid / out_ready   hit, way[2:0]
//
// Each item passes through accept/split, set row read, tag compare and way
// choice, then write-back. After reset the valid bits are swept clear one set
// per cycle, through every set, with in_ready low; config writes are taken
// throughout (cfg_ready is high).
// A result waits in its output register; the next item may be accepted
// meanwhile, and its write-back holds until the waiting result is taken.

module set_assoc_lru_cache_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [salc_pkg::ADDR_BITS-1:0]  address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [salc_pkg::WAY_W-1:0]      way
);

	salc_pkg::cmd_t cmd;

	// Config registers never stall.
	assign cfg_ready = 1'b1;

	// Sequence each item and own the result handshake.
	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Hold config, set memories and the result register.
	salc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.address   (address),
		.hit       (hit),
		.way       (way)
	);

endmodule

/* tb/tb_set_assoc_lru_cache_lookup.sv */
// Self-checking testbench for the set-associative cache lookup with LRU replacement.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_lookup;

	import salc_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 16;

	// Register index that maps to nothing; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		ACT_LOOKUP,	// send one address item
		ACT_WRITE,	// write one register once the block is idle
		ACT_PAUSE	// hold the sender until every result is back
	} act_e;

	typedef struct {
		act_e                  kind;
		logic [ADDR_BITS-1:0]  addr;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
	} plan_t;

	typedef struct {
		logic             hit;
		logic [WAY_W-1:0] way;
	} lookup_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [ADDR_BITS-1:0]  address   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic [WAY_W-1:0]      way;

	set_assoc_lru_cache_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.address   (address),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.way       (way)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: a private copy of the cache directory and the registers.
	// ------------------------------------------------------------------
	logic [TAG_W-1:0]  line_tag  [MAX_SETS][MAX_WAYS];
	bit                line_live [MAX_SETS][MAX_WAYS];
	logic [RANK_W-1:0] line_rank [MAX_SETS][MAX_WAYS];

	int unsigned cur_off  = OFFB_RESET;
	int unsigned cur_idx  = IDXB_RESET;
	int unsigned cur_ways = WIU_RESET;

	lookup_t lookups_due [$];
	plan_t   access_plan [$];

	int n_issued   = 0;	// items accepted by the block
	int n_returned = 0;	// results taken from the block
	int n_errors   = 0;

	// Mirror of the registers as the plan will have set them, so that the
	// address generator can aim at the split in effect.
	int unsigned plan_off  = OFFB_RESET;
	int unsigned plan_idx  = IDXB_RESET;
	int unsigned plan_ways = WIU_RESET;

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		n_errors++;
	endtask

	task automatic apply_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		case (sel)
			CFG_OFFSET_BITS: cur_off  = int'(val);
			CFG_INDEX_BITS:  cur_idx  = int'(val[IDXB_W-1:0]);
			CFG_WAYS_IN_USE: cur_ways = int'(val[WIU_W-1:0]);
			default: ;	// unknown index: drop the write
		endcase
	endtask

	// Look up one address, update the directory and return hit and way.
	function automatic lookup_t cache_access(input logic [ADDR_BITS-1:0] addr);
		lookup_t           res;
		logic [63:0]       a;
		logic [63:0]       mask;
		logic [63:0]       shifted;
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] limit;
		int unsigned       ways;
		int unsigned       set;
		int unsigned       shift;
		int                hit_way;
		int                free_way;
		int                pick;
		int                w;
		bit                age_all;
		a = {32'd0, addr};
		ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
		mask = (64'd1 << cur_idx) - 64'd1;
		shifted = (cur_off >= ADDR_BITS) ? 64'd0 : (a >> cur_off);
		// Index fields wider than the store wrap around it.
		set = int'(shifted & mask) % MAX_SETS;
		shift = cur_off + cur_idx;
		shifted = (shift >= ADDR_BITS) ? 64'd0 : (a >> shift);
		tag = shifted[TAG_W-1:0];

		// Duplicate tags after a register change: the highest way wins.
		hit_way = -1;
		for (w = 0; w < ways; w++)
			if (line_live[set][w] && line_tag[set][w] == tag)
				hit_way = w;

		if (hit_way >= 0) begin
			pick = hit_way;
			age_all = 1'b0;
			limit = line_rank[set][pick];
		end else begin
			free_way = -1;
			for (w = 0; w < ways; w++)
				if (!line_live[set][w] && free_way < 0)
					free_way = w;
			if (free_way >= 0) begin
				pick = free_way;
				age_all = 1'b1;
				limit = '0;
			end else begin
				// Rank ties go to the lowest way.
				pick = 0;
				for (w = 1; w < ways; w++)
					if (line_rank[set][w] > line_rank[set][pick])
						pick = w;
				age_all = 1'b0;
				limit = line_rank[set][pick];
			end
		end

		for (w = 0; w < ways; w++)
			if (line_live[set][w] && w != pick && (age_all || line_rank[set][w] < limit)
			    && line_rank[set][w] < ways - 1)
				line_rank[set][w] = line_rank[set][w] + 1'b1;
		line_rank[set][pick] = '0;
		if (hit_way < 0) begin
			line_tag[set][pick] = tag;
			line_live[set][pick] = 1'b1;
		end

		res.hit = (hit_way >= 0);
		res.way = pick[WAY_W-1:0];
		return res;
	endfunction

	// Draw a wait; now and then toggle into or out of a stretch with none.
	function automatic int pick_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 11));
	endfunction

	// ------------------------------------------------------------------
	// Driver: feed items and register writes from the plan queue.
	// ------------------------------------------------------------------
	bit hold_in;
	bit hold_cfg;
	bit next_in;
	bit next_cfg;
	bit send_calm = 1'b0;
	int send_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			address   <= '0;
			cfg_index <= '0;
			cfg_data  <= '0;
			send_wait = 0;
		end else begin
			hold_in  = in_valid && !in_ready;
			hold_cfg = cfg_valid && !cfg_ready;
			// Predict at acceptance, with the registers in effect right now.
			if (in_valid && in_ready) begin
				lookups_due.push_back(cache_access(address));
				n_issued <= n_issued + 1;
			end
			if (cfg_valid && cfg_ready)
				apply_cfg(cfg_index, cfg_data);
			next_in  = hold_in;
			next_cfg = hold_cfg;
			if (!hold_in && !hold_cfg) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (access_plan.size() > 0) begin
					case (access_plan[0].kind)
						ACT_LOOKUP: begin
							address <= access_plan[0].addr;
							next_in = 1'b1;
							void'(access_plan.pop_front());
							send_wait = pick_gap(send_calm);
						end
						default: begin
							// Hold writes and pauses until nothing is in flight.
							if (!in_valid && !cfg_valid && n_issued == n_returned) begin
								if (access_plan[0].kind == ACT_WRITE) begin
									cfg_index <= access_plan[0].reg_sel;
									cfg_data  <= access_plan[0].reg_val;
									next_cfg = 1'b1;
								end
								void'(access_plan.pop_front());
							end
						end
					endcase
				end
			end
			in_valid  <= next_in;
			cfg_valid <= next_cfg;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall at random, compare each result with the oldest one due.
	// ------------------------------------------------------------------
	bit      recv_calm = 1'b0;
	int      recv_wait = 0;
	lookup_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (n_returned == n_issued) begin
					flag_mismatch($sformatf("result hit=%0b way=%0d with none due", hit, way));
				end else begin
					want = lookups_due.pop_front();
					n_returned <= n_returned + 1;
					if (hit !== want.hit)
						flag_mismatch($sformatf("item %0d: hit %0b, want %0b",
							n_returned, hit, want.hit));
					if (way !== want.way)
						flag_mismatch($sformatf("item %0d: way %0d, want %0d",
							n_returned, way, want.way));
				end
				recv_wait = pick_gap(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	// ------------------------------------------------------------------
	// Plan building.
	// ------------------------------------------------------------------
	task automatic add_lookup(input logic [ADDR_BITS-1:0] addr);
		plan_t p;
		p.kind = ACT_LOOKUP;
		p.addr = addr;
		p.reg_sel = '0;
		p.reg_val = '0;
		access_plan.push_back(p);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		plan_t p;
		p.kind = ACT_WRITE;
		p.addr = '0;
		p.reg_sel = sel;
		p.reg_val = val;
		access_plan.push_back(p);
		case (sel)
			CFG_OFFSET_BITS: plan_off  = int'(val);
			CFG_INDEX_BITS:  plan_idx  = int'(val[IDXB_W-1:0]);
			CFG_WAYS_IN_USE: plan_ways = int'(val[WIU_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic add_pause();
		plan_t p;
		p.kind = ACT_PAUSE;
		p.addr = '0;
		p.reg_sel = '0;
		p.reg_val = '0;
		access_plan.push_back(p);
	endtask

	task automatic add_split(input int unsigned off, input int unsigned idx,
	                         input int unsigned ways);
		add_write(CFG_OFFSET_BITS, CFG_DATA_W'(off));
		add_write(CFG_INDEX_BITS, CFG_DATA_W'(idx));
		add_write(CFG_WAYS_IN_USE, CFG_DATA_W'(ways));
	endtask

	// Mostly well-formed traffic: a few sets, a few more tags than ways, so
	// hits, fills and evictions all occur. The rest is raw noise.
	task automatic add_random(input int count, input int nsets);
		logic [63:0] a;
		int unsigned ways_eff;
		int unsigned tagv;
		int unsigned setv;
		ways_eff = (plan_ways == 0) ? 1 : ((plan_ways > MAX_WAYS) ? MAX_WAYS : plan_ways);
		repeat (count) begin
			if ($urandom_range(0, 99) < 75) begin
				tagv = $urandom_range(0, ways_eff + 2);
				setv = $urandom_range(0, nsets - 1);
				a = (64'(tagv) << (plan_off + plan_idx)) | (64'(setv) << plan_off)
				  | (64'($urandom) & ((64'd1 << plan_off) - 64'd1));
				add_lookup(a[ADDR_BITS-1:0]);
			end else begin
				add_lookup($urandom);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin : main_seq
		int k;
		int unsigned off_r;
		int unsigned idx_r;
		int unsigned ways_r;
		for (int s = 0; s < MAX_SETS; s++)
			for (int w = 0; w < MAX_WAYS; w++) begin
				line_live[s][w] = 1'b0;
				line_tag[s][w]  = '0;
				line_rank[s][w] = '0;
			end

		// Directed, at the reset split (offset 2, index 10, 8 ways).
		add_lookup(32'h0000_0000);
		add_lookup(32'h0000_0000);
		add_lookup(32'hFFFF_FFFF);
		add_lookup(32'hFFFF_FFFF);
		for (k = 1; k < 8; k++)
			add_lookup(32'(k) << 12);	// fill the rest of set 0
		add_lookup(32'h0000_3000);	// hit in the middle of the set
		add_lookup(32'h0000_9000);	// full set: evict the oldest
		add_lookup(32'h0000_A000);
		add_lookup(32'h0000_3000);
		add_lookup(32'h0000_0000);	// evicted tag comes back as a miss

		add_random(60, 4);
		add_pause();	// let every result come home before going on
		add_random(90, 4);

		// Extremes of the split and of the way count.
		add_split(0, 0, 1);
		add_random(60, 1);
		add_split(16, 10, 8);
		add_random(80, 4);
		add_split(31, 15, 15);	// tag shifted out, ways above max
		add_random(60, 2);
		add_split(20, 12, 0);	// zero ways act as one, index wraps
		add_random(60, 3);

		// Duplicate tags: shrink to one way, refill way 0 with way 1's tag,
		// then widen again so both ways match.
		add_write(CFG_SPARE, 5'd7);
		add_split(2, 10, 2);
		add_lookup((32'h0000_0123 << 12) | (32'd777 << 2));
		add_lookup((32'h0000_0456 << 12) | (32'd777 << 2));
		add_write(CFG_WAYS_IN_USE, 5'd1);
		add_lookup((32'h0000_0456 << 12) | (32'd777 << 2));
		add_write(CFG_WAYS_IN_USE, 5'd2);
		add_lookup((32'h0000_0456 << 12) | (32'd777 << 2));

		// Random splits; bit 4 of the write data is dropped by the narrow registers.
		repeat (4) begin
			off_r  = $urandom_range(0, 16);
			idx_r  = $urandom_range(0, 10) | ($urandom_range(0, 1) << 4);
			ways_r = $urandom_range(1, 8) | ($urandom_range(0, 1) << 4);
			add_split(off_r, idx_r, ways_r);
			add_random(70, $urandom_range(1, 6));
		end

		add_write(CFG_INDEX_BITS, 5'd26);	// reads back as 10
		add_write(CFG_OFFSET_BITS, 5'd2);
		add_write(CFG_WAYS_IN_USE, 5'd24);	// reads back as 8
		add_random(60, 3);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (access_plan.size() != 0 || in_valid || cfg_valid || n_issued != n_returned)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lookups_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", lookups_due.size()));

		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Hard stop if the block hangs.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
